FILE: hw/rtl/lngf_pkg.sv
// Shared types, constants and the filter coefficient table for the
// look-ahead noise gate. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lngf_pkg;

    // Default window and filter length
    localparam int GATE_WINDOW_DEF = 900;
    localparam int FIR_TAPS_DEF    = 10;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CIDX_W   = 4;            // coefficient table has 16 entries
    localparam int ACC_W    = 32;           // exact tap sum fits in 32 bits signed

    // Gain in units of 1/5000
    localparam int GAIN_W = 13;
    localparam logic [GAIN_W-1:0] GAIN_UP    = 13'd5;
    localparam logic [GAIN_W-1:0] GAIN_CAP   = 13'd4975;
    localparam logic [GAIN_W-1:0] GAIN_SNAP  = 13'd6;     // decay from below this gives 0
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 13'd4979;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Scaling by 1/(32768*5000): shift by 18, then divide by 625 through a
    // reciprocal multiply that is exact for 25-bit dividends.
    localparam int QUO_W  = 25;
    localparam int SHR1   = 18;
    localparam logic [25:0] RECIP_625 = 26'd54975582;
    localparam int RECIP_SHIFT = 35;
    localparam logic [QUO_W-1:0] QUO_SAT = 25'd20480000;  // 32768 * 625

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_GAIN,
        S_MAG,
        S_SCALE,
        S_OUT
    } t_state;

    // Q1.15 coefficients, oldest tap first; unused taps are zero
    function automatic logic signed [COEF_W-1:0] fir_coef(input logic [CIDX_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = -16'sd1438;
            4'd1:    c = -16'sd3148;
            4'd2:    c = 16'sd1502;
            4'd3:    c = 16'sd10319;
            4'd4:    c = 16'sd14861;
            4'd5:    c = 16'sd0;
            4'd6:    c = 16'sd10319;
            4'd7:    c = 16'sd1502;
            4'd8:    c = -16'sd3148;
            4'd9:    c = -16'sd1438;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lookahead_noise_gate_fir.sv
// Look-ahead noise gate with gain-scaled FIR on delayed samples.
// Depends on lngf_pkg (constants, state type, coefficient table).
`timescale 1ns / 1ps
`default_nettype none

// One sample item passes, after its acceptance, through the tap step (taps
// read, multiplied and summed), the gain, magnitude and scaling steps and the
// output step, where its result is loaded into the output register once the
// output side can take it. The single shared multiplier serves every tap
// product, the gain scaling and the reciprocal divide, and the sample memory
// has one read port (one tap read per cycle). The input is not ready while an
// item is in work, but an item may be accepted while the previous result
// waits in the output register. The sample memory has no clearing pass: no
// result leaves the block until GATE_WINDOW items have been taken, by which
// time every entry has been written. The threshold register resets to 128.
module lookahead_noise_gate_fir
    import lngf_pkg::*;
#(
    parameter int GATE_WINDOW = GATE_WINDOW_DEF,
    parameter int FIR_TAPS    = FIR_TAPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration: gate_threshold
    input  wire logic                  i_cfg_we,
    input  wire logic [15:0]           i_cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,   // [15:0] sample_in
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]                 m_axis_tuser    // [0] gate_open
);

    localparam int AW = $clog2(GATE_WINDOW);
    localparam int CW = $clog2(GATE_WINDOW + 1);
    localparam int TW = $clog2(FIR_TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(GATE_WINDOW - 1);
    localparam logic [CW-1:0] WIN_CNT   = CW'(GATE_WINDOW);
    localparam logic [TW-1:0] TAP_CNT   = TW'(FIR_TAPS);

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + 1'b1;
    endfunction

    // state and control registers
    t_state                 r_state, n_state;
    logic [15:0]            r_thresh;
    logic [AW-1:0]          r_wp;
    logic [AW-1:0]          r_rd_addr;
    logic [CW-1:0]          r_since;
    logic [CW-1:0]          r_warm;
    logic [GAIN_W-1:0]      r_gain;
    logic                   r_open;
    logic                   r_emit;
    logic [TW-1:0]          r_cnt;
    logic                   r_v1, r_v2;
    logic [CIDX_W-1:0]      r_ci;

    // datapath registers
    logic signed [SAMPLE_W-1:0] r_mem [GATE_WINDOW];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_P_W-1:0]  r_prod;
    logic [QUO_W-1:0]           r_q;
    logic                       r_neg;
    logic                       r_sat;

    logic accept;
    logic issue;
    logic out_load;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign issue    = (r_cnt < TAP_CNT);
    assign out_load = (r_state == S_OUT) && r_emit && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = (r_state == S_IDLE);

    // gate and gain update for the incoming sample
    logic signed [16:0] s_ext;
    logic [16:0]        s_mag;
    logic               loud;
    logic [CW-1:0]      since_nx;
    logic               open_nx;
    logic [GAIN_W-1:0]  gain_nx;
    logic [AW-1:0]      wp_nx;

    always_comb begin
        s_ext    = {s_axis_tdata[15], s_axis_tdata};
        s_mag    = s_ext[16] ? 17'(-s_ext) : 17'(s_ext);
        loud     = (s_mag > {1'b0, r_thresh});
        if (loud) begin
            since_nx = '0;
        end else if (r_since < WIN_CNT) begin
            since_nx = r_since + 1'b1;
        end else begin
            since_nx = r_since;
        end
        open_nx = (since_nx < WIN_CNT);
        if (open_nx) begin
            gain_nx = (r_gain < GAIN_CAP) ? r_gain + GAIN_UP : r_gain;
        end else begin
            gain_nx = (r_gain < GAIN_SNAP) ? '0 : r_gain - 1'b1;
        end
        wp_nx = addr_inc(r_wp);
    end

    // shared multiplier: tap products, gain scaling, reciprocal divide
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_GAIN: begin
                mul_a = MUL_A_W'(r_acc);
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, r_gain});
            end
            S_SCALE: begin
                mul_a = $signed({{(MUL_A_W-QUO_W){1'b0}}, r_q});
                mul_b = $signed({1'b0, RECIP_625});
            end
            default: begin
                mul_a = MUL_A_W'(r_rdata);
                mul_b = MUL_B_W'(fir_coef(r_ci));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // magnitude of the scaled sum, first shift stage
    logic [MUL_P_W-1:0] p_mag;
    assign p_mag = r_prod[MUL_P_W-1] ? MUL_P_W'(-r_prod) : MUL_P_W'(r_prod);

    // final quotient with sign and saturation
    logic [14:0]              y_mag;
    logic signed [15:0]       y_val;
    assign y_mag = r_prod[RECIP_SHIFT+14:RECIP_SHIFT];
    always_comb begin
        if (r_sat) begin
            y_val = r_neg ? 16'sh8000 : 16'sh7FFF;
        end else if (r_neg) begin
            y_val = -$signed({1'b0, y_mag});
        end else begin
            y_val = $signed({1'b0, y_mag});
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_TAP;
            S_TAP:   if (!issue && !r_v1 && r_v2) n_state = S_GAIN;
            S_GAIN:  n_state = S_MAG;
            S_MAG:   n_state = S_SCALE;
            S_SCALE: n_state = S_OUT;
            S_OUT:   if (!r_emit || out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration, gate state, warm-up count, tap sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= 16'd128;
            r_wp      <= '0;
            r_rd_addr <= '0;
            r_since   <= WIN_CNT;
            r_warm    <= '0;
            r_gain    <= '0;
            r_open    <= 1'b0;
            r_emit    <= 1'b0;
            r_cnt     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_ci      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (accept) begin
                r_wp      <= wp_nx;
                r_rd_addr <= addr_inc(wp_nx);
                r_since   <= since_nx;
                r_gain    <= gain_nx;
                r_open    <= open_nx;
                r_emit    <= (r_warm == WIN_CNT);
                if (r_warm < WIN_CNT) begin
                    r_warm <= r_warm + 1'b1;
                end
                r_cnt <= '0;
            end
            if (r_state == S_TAP) begin
                r_v1 <= issue;
                r_v2 <= r_v1;
                if (issue) begin
                    r_ci      <= CIDX_W'(r_cnt);
                    r_cnt     <= r_cnt + 1'b1;
                    r_rd_addr <= addr_inc(r_rd_addr);
                end
            end else begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
            end
        end
    end

    // sample memory: one write at acceptance, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wp_nx] <= $signed(s_axis_tdata);
        end
        r_rdata <= r_mem[r_rd_addr];
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= '0;
        end
        case (r_state)
            S_TAP: begin
                if (r_v1) begin
                    r_prod <= mul_p;
                end
                if (r_v2) begin
                    r_acc <= r_acc + r_prod[ACC_W-1:0];
                end
            end
            S_GAIN: begin
                r_prod <= mul_p;
            end
            S_MAG: begin
                r_neg <= r_prod[MUL_P_W-1];
                r_q   <= p_mag[SHR1+QUO_W-1:SHR1];
                r_sat <= (p_mag[SHR1+QUO_W-1:SHR1] >= QUO_SAT);
            end
            S_SCALE: begin
                r_prod <= mul_p;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            m_axis_tdata <= y_val;
            m_axis_tuser <= r_open;
        end
    end

    // gain stays within its reachable range
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_MAX)
        else $error("gain above its maximum");

    // a new result only comes from the final sequencer step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside the output step");

    // tap pipeline is empty whenever the block is ready for a new item
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_v1 && !r_v2))
        else $error("tap pipeline busy while idle");

    // look-ahead counter never passes the window length
    a_since_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_since <= WIN_CNT)
        else $error("look-ahead counter out of range");

endmodule

`default_nettype wire
